// ===== hw/rtl/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// AABB collision package
// Widths, contact codes and the beat structures shared by the resolver
// stages.
// ----------------------------------------------------------------------------
package aabb_pkg;

   localparam int COORD_BITS   = 16;
   localparam int SIZE_BITS    = 12;
   localparam int PUSH_BITS    = 9;
   localparam int FRAC_BITS    = 8;
   localparam int CONTACT_BITS = 4;
   // Doubled-unit geometry needs room for twice a coordinate difference plus
   // a size, and a sign.
   localparam int WIDE_BITS    = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 3;
   localparam int MAG_BITS     = SIZE_BITS + 1;

   localparam logic [PUSH_BITS-1:0] FULL_PUSH = PUSH_BITS'(1 << FRAC_BITS);

   localparam logic FUNC_RESOLVE = 1'b0;
   localparam logic FUNC_DETECT  = 1'b1;

   localparam logic [CONTACT_BITS-1:0] CONTACT_NONE  = 4'd0;
   localparam logic [CONTACT_BITS-1:0] OVERLAP_RIGHT = 4'd1;
   localparam logic [CONTACT_BITS-1:0] OVERLAP_LEFT  = 4'd2;
   localparam logic [CONTACT_BITS-1:0] OVERLAP_DOWN  = 4'd3;
   localparam logic [CONTACT_BITS-1:0] OVERLAP_TOP   = 4'd4;
   localparam logic [CONTACT_BITS-1:0] TOUCH_RIGHT   = 4'd5;
   localparam logic [CONTACT_BITS-1:0] TOUCH_LEFT    = 4'd6;
   localparam logic [CONTACT_BITS-1:0] TOUCH_DOWN    = 4'd7;
   localparam logic [CONTACT_BITS-1:0] TOUCH_TOP     = 4'd8;

   typedef struct packed {
      logic                         func;
      logic signed [COORD_BITS-1:0] this_x;
      logic signed [COORD_BITS-1:0] this_y;
      logic [SIZE_BITS-1:0]         this_w;
      logic [SIZE_BITS-1:0]         this_h;
      logic signed [COORD_BITS-1:0] other_x;
      logic signed [COORD_BITS-1:0] other_y;
      logic [SIZE_BITS-1:0]         other_w;
      logic [SIZE_BITS-1:0]         other_h;
      logic [PUSH_BITS-1:0]         push_frac;
   } req_type;

   // Geometry stage result: classification plus what the move stage needs.
   typedef struct packed {
      logic [CONTACT_BITS-1:0]      contact;
      logic signed [COORD_BITS-1:0] this_x;
      logic signed [COORD_BITS-1:0] this_y;
      logic signed [COORD_BITS-1:0] other_x;
      logic signed [COORD_BITS-1:0] other_y;
      logic                         move_en;
      logic                         axis_y;
      logic                         dir_pos;
      logic                         full;
      logic [MAG_BITS-1:0]          mag;
      logic [PUSH_BITS-1:0]         factor;
      logic signed [WIDE_BITS-1:0]  other_adj;
      logic signed [WIDE_BITS-1:0]  snap;
   } geom_type;

   typedef struct packed {
      logic [CONTACT_BITS-1:0]      contact;
      logic signed [COORD_BITS-1:0] this_new_x;
      logic signed [COORD_BITS-1:0] this_new_y;
      logic signed [COORD_BITS-1:0] other_new_x;
      logic signed [COORD_BITS-1:0] other_new_y;
   } rsp_type;

endpackage

// ===== hw/rtl/aabb_geom.sv =====
// ----------------------------------------------------------------------------
// AABB geometry stage
// Measures the penetration on both axes, classifies the contact and prepares
// the operands of the push-apart move.
// ----------------------------------------------------------------------------
module aabb_geom (
   input  aabb_pkg::req_type  req,
   output aabb_pkg::geom_type geom
);

   localparam int C = aabb_pkg::COORD_BITS;
   localparam int S = aabb_pkg::SIZE_BITS;
   localparam int W = aabb_pkg::WIDE_BITS;

   logic signed [W-1:0] tx_e, ty_e, ox_e, oy_e;
   logic signed [W-1:0] tw_e, th_e, ow_e, oh_e;
   logic signed [W-1:0] sum_w, sum_h;
   logic signed [W-1:0] dx_r, dy_r, ix_r, iy_r;
   logic signed [W-1:0] dx_d, dy_d, ix_d, iy_d;
   logic signed [W-1:0] abs_dx_r, abs_dy_r, abs_dx_d, abs_dy_d;
   logic signed [W-1:0] pen, neg_pen, mag_e;
   logic signed [W-1:0] t_sel, o_sel, t_size, o_size;
   logic                overlap, x_axis, dir_pos, full;
   logic [aabb_pkg::PUSH_BITS-1:0] push_clamped;
   logic [aabb_pkg::CONTACT_BITS-1:0] contact;

   function automatic logic [aabb_pkg::CONTACT_BITS-1:0] classify(
      input logic use_x,
      input logic dx_pos,
      input logic dy_pos,
      input logic touch
   );
      logic [aabb_pkg::CONTACT_BITS-1:0] code;
      priority if (use_x && dx_pos) begin
         code = touch ? aabb_pkg::TOUCH_RIGHT : aabb_pkg::OVERLAP_RIGHT;
      end else if (use_x) begin
         code = touch ? aabb_pkg::TOUCH_LEFT : aabb_pkg::OVERLAP_LEFT;
      end else if (dy_pos) begin
         code = touch ? aabb_pkg::TOUCH_DOWN : aabb_pkg::OVERLAP_DOWN;
      end else begin
         code = touch ? aabb_pkg::TOUCH_TOP : aabb_pkg::OVERLAP_TOP;
      end
      return code;
   endfunction

   always_comb begin
      tx_e = {{(W-C){req.this_x[C-1]}}, req.this_x};
      ty_e = {{(W-C){req.this_y[C-1]}}, req.this_y};
      ox_e = {{(W-C){req.other_x[C-1]}}, req.other_x};
      oy_e = {{(W-C){req.other_y[C-1]}}, req.other_y};
      tw_e = {{(W-S){1'b0}}, req.this_w};
      th_e = {{(W-S){1'b0}}, req.this_h};
      ow_e = {{(W-S){1'b0}}, req.other_w};
      oh_e = {{(W-S){1'b0}}, req.other_h};
      sum_w = ow_e + tw_e;
      sum_h = oh_e + th_e;

      // Resolve mode works on doubled centres.
      dx_r = (ox_e <<< 1) + ow_e - (tx_e <<< 1) - tw_e;
      dy_r = (oy_e <<< 1) + oh_e - (ty_e <<< 1) - th_e;
      abs_dx_r = dx_r[W-1] ? -dx_r : dx_r;
      abs_dy_r = dy_r[W-1] ? -dy_r : dy_r;
      ix_r = abs_dx_r - sum_w;
      iy_r = abs_dy_r - sum_h;

      // Detect mode uses centres rounded down to whole units.
      dx_d = (ox_e + (ow_e >>> 1)) - (tx_e + (tw_e >>> 1));
      dy_d = (oy_e + (oh_e >>> 1)) - (ty_e + (th_e >>> 1));
      abs_dx_d = dx_d[W-1] ? -dx_d : dx_d;
      abs_dy_d = dy_d[W-1] ? -dy_d : dy_d;
      ix_d = (abs_dx_d <<< 1) - sum_w;
      iy_d = (abs_dy_d <<< 1) - sum_h;

      push_clamped = (req.push_frac > aabb_pkg::FULL_PUSH) ? aabb_pkg::FULL_PUSH
                                                           : req.push_frac;
      full    = (push_clamped == aabb_pkg::FULL_PUSH);
      overlap = (ix_r < 0) && (iy_r < 0);
      x_axis  = ix_r > iy_r;
      dir_pos = x_axis ? (dx_r > 0) : (dy_r > 0);

      pen     = x_axis ? ix_r : iy_r;
      neg_pen = -pen;
      mag_e   = {{(W-S-1){1'b0}}, neg_pen[S:0]};
      t_sel   = x_axis ? tx_e : ty_e;
      o_sel   = x_axis ? ox_e : oy_e;
      t_size  = x_axis ? tw_e : th_e;
      o_size  = x_axis ? ow_e : oh_e;

      contact = aabb_pkg::CONTACT_NONE;
      if (req.func == aabb_pkg::FUNC_RESOLVE) begin
         priority if (overlap) begin
            contact = classify(x_axis, dx_r > 0, dy_r > 0, full);
         end else if ((ix_r == 0) && (iy_r < 0)) begin
            contact = (dx_d > 0) ? aabb_pkg::TOUCH_RIGHT : aabb_pkg::TOUCH_LEFT;
         end else if ((iy_r == 0) && (ix_r < 0) && (dy_d < 0)) begin
            contact = aabb_pkg::TOUCH_TOP;
         end else begin
            contact = aabb_pkg::CONTACT_NONE;
         end
      end else begin
         priority if ((ix_d < 0) && (iy_d < 0)) begin
            contact = classify(ix_d > iy_d, dx_d > 0, dy_d > 0, 1'b0);
         end else if ((ix_d <= 0) && (iy_d <= 0)) begin
            contact = classify(ix_d > iy_d, dx_d > 0, dy_d > 0, 1'b1);
         end else begin
            contact = aabb_pkg::CONTACT_NONE;
         end
      end

      geom.contact   = contact;
      geom.this_x    = req.this_x;
      geom.this_y    = req.this_y;
      geom.other_x   = req.other_x;
      geom.other_y   = req.other_y;
      geom.move_en   = (req.func == aabb_pkg::FUNC_RESOLVE) && overlap;
      geom.axis_y    = !x_axis;
      geom.dir_pos   = dir_pos;
      geom.full      = full;
      geom.mag       = neg_pen[S:0];
      geom.factor    = aabb_pkg::FULL_PUSH - push_clamped;
      // The other box is first pushed clear by the whole penetration; the
      // move stage then hands back the share that falls to it.
      geom.other_adj = dir_pos ? (o_sel + mag_e) : (o_sel - mag_e);
      geom.snap      = dir_pos ? (t_sel + t_size) : (t_sel - o_size);
   end

endmodule

// ===== hw/rtl/aabb_move.sv =====
// ----------------------------------------------------------------------------
// AABB move stage
// Scales the penetration by the push share, applies the move to both boxes
// and saturates the new positions.
// ----------------------------------------------------------------------------
module aabb_move (
   input  aabb_pkg::geom_type geom,
   output aabb_pkg::rsp_type  rsp
);

   localparam int C = aabb_pkg::COORD_BITS;
   localparam int M = aabb_pkg::MAG_BITS;
   localparam int W = aabb_pkg::WIDE_BITS;
   localparam int P = aabb_pkg::PUSH_BITS;
   localparam int F = aabb_pkg::FRAC_BITS;

   logic [M+P-1:0]      prod;
   logic signed [W-1:0] share_e, t_e, new_this, new_other;
   logic signed [C-1:0] sat_this, sat_other;

   function automatic logic signed [C-1:0] saturate(input logic signed [W-1:0] v);
      logic signed [C-1:0] r;
      if ((&v[W-1:C-1]) || !(|v[W-1:C-1])) begin
         r = v[C-1:0];
      end else if (v[W-1]) begin
         r = {1'b1, {(C-1){1'b0}}};
      end else begin
         r = {1'b0, {(C-1){1'b1}}};
      end
      return r;
   endfunction

   always_comb begin
      // The product never exceeds mag shifted up by the fraction bits, so the
      // truncated share fits in the width of mag.
      prod    = {{P{1'b0}}, geom.mag} * {{M{1'b0}}, geom.factor};
      share_e = {{(W-M){1'b0}}, prod[M+F-1:F]};
      t_e     = geom.axis_y ? {{(W-C){geom.this_y[C-1]}}, geom.this_y}
                            : {{(W-C){geom.this_x[C-1]}}, geom.this_x};

      if (geom.full) begin
         new_this  = t_e;
         new_other = geom.snap;
      end else if (geom.dir_pos) begin
         new_this  = t_e - share_e;
         new_other = geom.other_adj - share_e;
      end else begin
         new_this  = t_e + share_e;
         new_other = geom.other_adj + share_e;
      end
      sat_this  = saturate(new_this);
      sat_other = saturate(new_other);

      rsp.contact     = geom.contact;
      rsp.this_new_x  = geom.this_x;
      rsp.this_new_y  = geom.this_y;
      rsp.other_new_x = geom.other_x;
      rsp.other_new_y = geom.other_y;
      if (geom.move_en && geom.axis_y) begin
         rsp.this_new_y  = sat_this;
         rsp.other_new_y = sat_other;
      end else if (geom.move_en) begin
         rsp.this_new_x  = sat_this;
         rsp.other_new_x = sat_other;
      end
   end

endmodule

// ===== hw/rtl/aabb_collision_resolver_unit.sv =====
// ----------------------------------------------------------------------------
// AABB collision resolver
// Contact test and push-apart resolution of two axis-aligned boxes.
// ----------------------------------------------------------------------------
//  Channel   Ports                 Handshake
//  request   start, busy, req_*    beat taken when start is high, busy low
//  result    rsp_valid, rsp_*      one-cycle strobe, always taken
//
//  One beat is taken every cycle; busy is never raised.
//  The result strobe rises when the result register is loaded; a request
//  passes through the input register, the geometry register and the result
//  register.
//  The geometry stage and the single push multiplier set the clock period.
//  Reset clears the valid flags only; results in flight are dropped, none is invented.
// ----------------------------------------------------------------------------
module aabb_collision_resolver_unit (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic                                       req_func,
   input  logic signed [aabb_pkg::COORD_BITS-1:0]     req_this_x,
   input  logic signed [aabb_pkg::COORD_BITS-1:0]     req_this_y,
   input  logic [aabb_pkg::SIZE_BITS-1:0]             req_this_w,
   input  logic [aabb_pkg::SIZE_BITS-1:0]             req_this_h,
   input  logic signed [aabb_pkg::COORD_BITS-1:0]     req_other_x,
   input  logic signed [aabb_pkg::COORD_BITS-1:0]     req_other_y,
   input  logic [aabb_pkg::SIZE_BITS-1:0]             req_other_w,
   input  logic [aabb_pkg::SIZE_BITS-1:0]             req_other_h,
   input  logic [aabb_pkg::PUSH_BITS-1:0]             req_push_frac,
   output logic                                       rsp_valid,
   output logic [aabb_pkg::CONTACT_BITS-1:0]          rsp_contact,
   output logic signed [aabb_pkg::COORD_BITS-1:0]     rsp_this_new_x,
   output logic signed [aabb_pkg::COORD_BITS-1:0]     rsp_this_new_y,
   output logic signed [aabb_pkg::COORD_BITS-1:0]     rsp_other_new_x,
   output logic signed [aabb_pkg::COORD_BITS-1:0]     rsp_other_new_y
);

   logic               accept;
   logic               req_valid_ff, geom_valid_ff, rsp_valid_ff;
   aabb_pkg::req_type  req_ff, req_in;
   aabb_pkg::geom_type geom_ff, geom_in;
   aabb_pkg::rsp_type  rsp_ff, rsp_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      req_in.func      = req_func;
      req_in.this_x    = req_this_x;
      req_in.this_y    = req_this_y;
      req_in.this_w    = req_this_w;
      req_in.this_h    = req_this_h;
      req_in.other_x   = req_other_x;
      req_in.other_y   = req_other_y;
      req_in.other_w   = req_other_w;
      req_in.other_h   = req_other_h;
      req_in.push_frac = req_push_frac;
   end

   aabb_geom u_geom (
      .req  (req_ff),
      .geom (geom_in)
   );

   aabb_move u_move (
      .geom (geom_ff),
      .rsp  (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         geom_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         req_valid_ff  <= accept;
         geom_valid_ff <= req_valid_ff;
         rsp_valid_ff  <= geom_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      if (req_valid_ff) begin
         geom_ff <= geom_in;
      end
      if (geom_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_contact     = rsp_ff.contact;
   assign rsp_this_new_x  = rsp_ff.this_new_x;
   assign rsp_this_new_y  = rsp_ff.this_new_y;
   assign rsp_other_new_x = rsp_ff.other_new_x;
   assign rsp_other_new_y = rsp_ff.other_new_y;

endmodule

// ===== tb/aabb_collision_resolver_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AABB collision resolver testbench
// Drives box pairs into the resolver through the start/busy port and checks
// every result strobe against a behavioural prediction of contact code and
// resolved positions. A directed set covers the overlap directions, full and
// over-full push, axis ties, touches, detect mode and saturation. Random
// pairs follow, mostly overlapping or touching, with random sender gaps.
// ----------------------------------------------------------------------------
module aabb_collision_resolver_unit_test;

   localparam int COORD_BITS   = aabb_pkg::COORD_BITS;
   localparam int SIZE_BITS    = aabb_pkg::SIZE_BITS;
   localparam int PUSH_BITS    = aabb_pkg::PUSH_BITS;
   localparam int CONTACT_BITS = aabb_pkg::CONTACT_BITS;

   localparam int RANDOM_PAIRS = 1200;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   class box_pair_scoreboard;
      aabb_pkg::rsp_type expected_outcomes[$];
      int      failures;

      function new();
         failures = 0;
      endfunction

      function logic signed [COORD_BITS-1:0] clamp_coord(longint v);
         longint hi;
         longint lo;
         hi = (longint'(1) << (COORD_BITS - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) v = hi;
         if (v < lo) v = lo;
         return COORD_BITS'(v);
      endfunction

      function logic [CONTACT_BITS-1:0] axis_contact(longint ix, longint iy, longint dx,
                                                     longint dy, bit touching);
         if (ix > iy) begin
            if (dx > 0) return touching ? aabb_pkg::TOUCH_RIGHT : aabb_pkg::OVERLAP_RIGHT;
            return touching ? aabb_pkg::TOUCH_LEFT : aabb_pkg::OVERLAP_LEFT;
         end
         if (dy > 0) return touching ? aabb_pkg::TOUCH_DOWN : aabb_pkg::OVERLAP_DOWN;
         return touching ? aabb_pkg::TOUCH_TOP : aabb_pkg::OVERLAP_TOP;
      endfunction

      function aabb_pkg::rsp_type predict_outcome(aabb_pkg::req_type r);
         longint tx, ty, tw, th, ox, oy, ow, oh, p;
         longint dx, dy, ix, iy, mv, full_push;
         longint ntx, nty, nox, noy;
         logic [CONTACT_BITS-1:0] c;
         bit full;
         aabb_pkg::rsp_type o;
         tx = $signed(r.this_x);
         ty = $signed(r.this_y);
         ox = $signed(r.other_x);
         oy = $signed(r.other_y);
         tw = r.this_w;
         th = r.this_h;
         ow = r.other_w;
         oh = r.other_h;
         p  = r.push_frac;
         full_push = aabb_pkg::FULL_PUSH;
         ntx = tx;
         nty = ty;
         nox = ox;
         noy = oy;
         c = aabb_pkg::CONTACT_NONE;
         if (r.func == aabb_pkg::FUNC_RESOLVE) begin
            // Resolve mode works in doubled units and applies the move unhalved.
            dx = 2 * ox + ow - 2 * tx - tw;
            dy = 2 * oy + oh - 2 * ty - th;
            ix = ((dx < 0) ? -dx : dx) - (ow + tw);
            iy = ((dy < 0) ? -dy : dy) - (oh + th);
            if (p > full_push) p = full_push;
            full = (p == full_push);
            if (ix < 0 && iy < 0) begin
               if (ix > iy) begin
                  mv = ix * (full_push - p) / full_push;
                  if (dx > 0) begin
                     if (full) begin
                        nox = tx + tw;
                        c = aabb_pkg::TOUCH_RIGHT;
                     end else begin
                        ntx = tx + mv;
                        nox = ox - ix + mv;
                        c = aabb_pkg::OVERLAP_RIGHT;
                     end
                  end else begin
                     if (full) begin
                        nox = tx - ow;
                        c = aabb_pkg::TOUCH_LEFT;
                     end else begin
                        ntx = tx - mv;
                        nox = ox + ix - mv;
                        c = aabb_pkg::OVERLAP_LEFT;
                     end
                  end
               end else begin
                  mv = iy * (full_push - p) / full_push;
                  if (dy > 0) begin
                     if (full) begin
                        noy = ty + th;
                        c = aabb_pkg::TOUCH_DOWN;
                     end else begin
                        nty = ty + mv;
                        noy = oy - iy + mv;
                        c = aabb_pkg::OVERLAP_DOWN;
                     end
                  end else begin
                     if (full) begin
                        noy = ty - oh;
                        c = aabb_pkg::TOUCH_TOP;
                     end else begin
                        nty = ty - mv;
                        noy = oy + iy - mv;
                        c = aabb_pkg::OVERLAP_TOP;
                     end
                  end
               end
            end else if (ix == 0 && iy < 0) begin
               c = (tx + tw / 2 < ox + ow / 2) ? aabb_pkg::TOUCH_RIGHT : aabb_pkg::TOUCH_LEFT;
            end else if (iy == 0 && ix < 0 && (oy + oh / 2 < ty + th / 2)) begin
               c = aabb_pkg::TOUCH_TOP;
            end
         end else begin
            dx = (ox + ow / 2) - (tx + tw / 2);
            dy = (oy + oh / 2) - (ty + th / 2);
            ix = 2 * ((dx < 0) ? -dx : dx) - (ow + tw);
            iy = 2 * ((dy < 0) ? -dy : dy) - (oh + th);
            if (ix < 0 && iy < 0)
               c = axis_contact(ix, iy, dx, dy, 1'b0);
            else if (ix <= 0 && iy <= 0)
               c = axis_contact(ix, iy, dx, dy, 1'b1);
         end
         o.contact     = c;
         o.this_new_x  = clamp_coord(ntx);
         o.this_new_y  = clamp_coord(nty);
         o.other_new_x = clamp_coord(nox);
         o.other_new_y = clamp_coord(noy);
         return o;
      endfunction

      function void note_pair(aabb_pkg::req_type r);
         expected_outcomes.push_back(predict_outcome(r));
      endfunction

      function void check_outcome(aabb_pkg::rsp_type got);
         aabb_pkg::rsp_type want;
         if (expected_outcomes.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result beat: contact %0d pos %0d %0d %0d %0d",
                        got.contact, got.this_new_x, got.this_new_y,
                        got.other_new_x, got.other_new_y);
            return;
         end
         want = expected_outcomes.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display({"result mismatch: expected contact %0d pos %0d %0d %0d %0d, ",
                         "got contact %0d pos %0d %0d %0d %0d"},
                        want.contact, want.this_new_x, want.this_new_y,
                        want.other_new_x, want.other_new_y,
                        got.contact, got.this_new_x, got.this_new_y,
                        got.other_new_x, got.other_new_y);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = aabb_pkg::FUNC_RESOLVE;
   logic signed [COORD_BITS-1:0] req_this_x = '0;
   logic signed [COORD_BITS-1:0] req_this_y = '0;
   logic [SIZE_BITS-1:0] req_this_w = '0;
   logic [SIZE_BITS-1:0] req_this_h = '0;
   logic signed [COORD_BITS-1:0] req_other_x = '0;
   logic signed [COORD_BITS-1:0] req_other_y = '0;
   logic [SIZE_BITS-1:0] req_other_w = '0;
   logic [SIZE_BITS-1:0] req_other_h = '0;
   logic [PUSH_BITS-1:0] req_push_frac = '0;
   logic rsp_valid;
   logic [CONTACT_BITS-1:0] rsp_contact;
   logic signed [COORD_BITS-1:0] rsp_this_new_x;
   logic signed [COORD_BITS-1:0] rsp_this_new_y;
   logic signed [COORD_BITS-1:0] rsp_other_new_x;
   logic signed [COORD_BITS-1:0] rsp_other_new_y;

   box_pair_scoreboard outcome_board = new();
   int idle_cycles = 0;

   aabb_collision_resolver_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_this_x      (req_this_x),
      .req_this_y      (req_this_y),
      .req_this_w      (req_this_w),
      .req_this_h      (req_this_h),
      .req_other_x     (req_other_x),
      .req_other_y     (req_other_y),
      .req_other_w     (req_other_w),
      .req_other_h     (req_other_h),
      .req_push_frac   (req_push_frac),
      .rsp_valid       (rsp_valid),
      .rsp_contact     (rsp_contact),
      .rsp_this_new_x  (rsp_this_new_x),
      .rsp_this_new_y  (rsp_this_new_y),
      .rsp_other_new_x (rsp_other_new_x),
      .rsp_other_new_y (rsp_other_new_y)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0)
         outcome_board.check_outcome(aabb_pkg::rsp_type'{contact:     rsp_contact,
                                                         this_new_x:  rsp_this_new_x,
                                                         this_new_y:  rsp_this_new_y,
                                                         other_new_x: rsp_other_new_x,
                                                         other_new_y: rsp_other_new_y});
   end

   // Any cycle without a request or a result beat counts towards the stall limit.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic aabb_pkg::req_type make_pair(logic f, int tx, int ty, int tw, int th,
                                                   int ox, int oy, int ow, int oh, int p);
      aabb_pkg::req_type r;
      r.func      = f;
      r.this_x    = COORD_BITS'(tx);
      r.this_y    = COORD_BITS'(ty);
      r.this_w    = SIZE_BITS'(tw);
      r.this_h    = SIZE_BITS'(th);
      r.other_x   = COORD_BITS'(ox);
      r.other_y   = COORD_BITS'(oy);
      r.other_w   = SIZE_BITS'(ow);
      r.other_h   = SIZE_BITS'(oh);
      r.push_frac = PUSH_BITS'(p);
      return r;
   endfunction

   function automatic int rand_coord();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return 32767 - int'($urandom_range(0, 4200));
      if (roll == 1) return -32768 + int'($urandom_range(0, 4200));
      return int'($signed(16'($urandom)));
   endfunction

   function automatic int rand_size();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 0;
      if (roll == 1) return 4095;
      if (roll < 4) return $urandom_range(0, 4095);
      return $urandom_range(1, 64);
   endfunction

   function automatic int rand_push();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 0;
      if (roll == 1) return 256;
      if (roll == 2) return $urandom_range(257, 511);
      return $urandom_range(0, 255);
   endfunction

   // Most pairs overlap or touch so that the resolve paths are exercised;
   // the rest are unrelated boxes or near misses.
   function automatic aabb_pkg::req_type make_random_pair();
      int tx, ty, tw, th, ox, oy, ow, oh, kind, side;
      logic f;
      kind = $urandom_range(0, 99);
      side = $urandom_range(0, 3);
      f  = ($urandom_range(0, 9) < 3) ? aabb_pkg::FUNC_DETECT : aabb_pkg::FUNC_RESOLVE;
      tw = rand_size();
      th = rand_size();
      ow = rand_size();
      oh = rand_size();
      tx = rand_coord();
      ty = rand_coord();
      ox = tx - ow + int'($urandom_range(0, tw + ow));
      oy = ty - oh + int'($urandom_range(0, th + oh));
      if (kind < 12) begin
         ox = rand_coord();
         oy = rand_coord();
      end else if (kind >= 70 && kind < 90) begin
         case (side)
            0: ox = tx + tw;
            1: ox = tx - ow;
            2: oy = ty + th;
            default: oy = ty - oh;
         endcase
      end else if (kind >= 90) begin
         if (side[0]) ox = tx + tw + int'($urandom_range(0, 8));
         else         ox = tx - ow - int'($urandom_range(0, 8));
      end
      return make_pair(f, tx, ty, tw, th, ox, oy, ow, oh, rand_push());
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   task automatic send_pair(input aabb_pkg::req_type r);
      start         <= 1'b1;
      req_func      <= r.func;
      req_this_x    <= r.this_x;
      req_this_y    <= r.this_y;
      req_this_w    <= r.this_w;
      req_this_h    <= r.this_h;
      req_other_x   <= r.other_x;
      req_other_y   <= r.other_y;
      req_other_w   <= r.other_w;
      req_other_h   <= r.other_h;
      req_push_frac <= r.push_frac;
      do @(posedge clock); while (busy !== 1'b0);
      outcome_board.note_pair(r);
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_all_outcomes();
      start <= 1'b0;
      @(posedge clock);
      while (outcome_board.expected_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic run_directed_pairs();
      aabb_pkg::req_type pairs[$];
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 0, 0, 10, 10, 6, 2, 10, 10, 128));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 0, 0, 10, 10, -6, 2, 10, 10, 128));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 0, 0, 10, 10, 2, 7, 10, 10, 77));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 0, 0, 10, 10, 2, -7, 10, 10, 200));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 0, 0, 10, 10, 6, 2, 10, 10, 256));
      // Push fraction above one behaves as a full push.
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 0, 0, 10, 10, -6, 2, 10, 10, 511));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 0, 0, 10, 10, 2, 7, 10, 10, 0));
      // Equal penetration on both axes takes the vertical axis.
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 0, 0, 10, 10, 4, 4, 10, 10, 100));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 0, 0, 10, 10, 10, 3, 10, 10, 64));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 0, 0, 10, 10, -10, 3, 10, 10, 64));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 0, 0, 10, 10, 3, -10, 10, 10, 64));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 0, 0, 10, 10, 3, 10, 10, 10, 64));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 0, 0, 10, 10, 10, 10, 10, 10, 64));
      pairs.push_back(make_pair(aabb_pkg::FUNC_DETECT, 0, 0, 10, 10, 6, 2, 10, 10, 128));
      pairs.push_back(make_pair(aabb_pkg::FUNC_DETECT, 0, 0, 10, 10, 2, -7, 10, 10, 0));
      pairs.push_back(make_pair(aabb_pkg::FUNC_DETECT, 0, 0, 7, 9, 7, 0, 5, 5, 256));
      pairs.push_back(make_pair(aabb_pkg::FUNC_DETECT, 0, 0, 10, 10, 100, 100, 10, 10, 0));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 5, 5, 0, 0, 5, 5, 0, 0, 128));
      pairs.push_back(make_pair(aabb_pkg::FUNC_DETECT, 5, 5, 0, 0, 5, 5, 0, 0, 128));
      // Pushes that run past either end of the coordinate range.
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 32760, 0, 4095, 4095, 32761, 0,
                                4095, 4095, 256));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, -32760, 0, 4095, 4095, -32768, 0,
                                4095, 4095, 256));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, 30000, 0, 4095, 4095, 30001, 0,
                                4095, 4095, 128));
      pairs.push_back(make_pair(aabb_pkg::FUNC_RESOLVE, -32768, -32768, 4095, 4095, 32767,
                                32767, 4095, 4095, 511));
      pairs.push_back(make_pair(aabb_pkg::FUNC_DETECT, -32768, -32768, 4095, 4095, 32767,
                                32767, 4095, 4095, 511));
      foreach (pairs[i]) begin
         send_pair(pairs[i]);
         idle_gap(pick_gap());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed_pairs();
      wait_all_outcomes();
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         if (i % 300 == 150) wait_all_outcomes();
         send_pair(make_random_pair());
         // Every fourth block of a hundred beats runs back to back.
         if ((i / 100) % 4 != 3) idle_gap(pick_gap());
      end
      wait_all_outcomes();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (outcome_board.failures == 0 && outcome_board.expected_outcomes.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
